@@ rtl/core/ecpid_pkg.sv @@
// ----------------------------------------------------------------------------
// ecpid_pkg
// Types, register indexes, states and the quadrature step table.
// ----------------------------------------------------------------------------
`default_nettype none
package ecpid_pkg;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 47;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_KP       = 3'd0,
        CFG_KI       = 3'd1,
        CFG_KD       = 3'd2,
        CFG_MAX_INT  = 3'd3,
        CFG_SCALE    = 3'd4,
        CFG_WINDOW   = 3'd5,
        CFG_REVERSE  = 3'd6,
        CFG_UNUSED   = 3'd7
    } t_cfg_idx;

    localparam logic signed [31:0] KP_RESET      = 32'sd65536;
    localparam logic [46:0]        MAX_INT_RESET = 47'h7FFF_FFFF_FFFF;
    localparam logic [31:0]        SCALE_RESET   = 32'd65536;
    localparam logic [19:0]        WINDOW_RESET  = 20'd5000;

    localparam logic [63:0] PROD_CAP = 64'h0002_0000_0000_0000;
    localparam logic [63:0] INT_CAP  = 64'h0000_0100_0000_0000;

    typedef struct packed {
        logic signed [31:0] kp;
        logic signed [31:0] ki;
        logic signed [31:0] kd;
        logic [46:0]        max_int;
        logic [31:0]        scale;
        logic [19:0]        window;
        logic               reverse;
    } t_cfg;

    typedef struct packed {
        logic [31:0]        now;
        logic signed [31:0] target;
        logic [31:0]        ticks;
    } t_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPDM,
        S_SPDD,
        S_SPDW,
        S_ERR,
        S_INTM,
        S_INTA,
        S_PA,
        S_IA1,
        S_IA2,
        S_DA,
        S_DW,
        S_PWR,
        S_DUTY,
        S_FIN
    } t_state;

    function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
        logic signed [1:0] s;
        unique case (idx)
            4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
            default:                 s = 2'sd0;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/encoder_pid_speed_controller.sv @@
// ----------------------------------------------------------------------------
// encoder_pid_speed_controller
// Quadrature tick counter with a PID speed loop and PWM duty output.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall): i_cmd 0 carries a pin sample,
// i_cmd 1 a control update with a timestamp and a target speed.
// A pin sample is taken in and counted, and gives no result.
// Each control update gives one result transaction on the output channel
// (o_out_valid / i_out_stall) with tick delta, speed, duty and direction.
// A control update steps through the back-end states to its result; a
// new speed estimate adds a division, and the derivative division is
// skipped when dt is zero: each 64-bit division runs one quotient bit a
// cycle in a shared divider, and multiplies share one registered 32x32 unit.
// Up to two control updates wait in a queue while pin samples keep being
// counted; the input stalls only when that queue is full.
// When the receiver stalls, the result holds in the output register and
// the next update waits finished until the register frees.
// Reset (synchronous, active low) clears counters, PID state and loads
// the default gains. Configuration writes (i_cfg_we, i_cfg_idx,
// i_cfg_data) take effect at once and belong in idle periods.
// ----------------------------------------------------------------------------
`default_nettype none
module encoder_pid_speed_controller #(
    parameter int DUTY_BITS = 12,
    parameter int TICK_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [ecpid_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [ecpid_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_cmd,
    input  wire logic        i_pin_a,
    input  wire logic        i_pin_b,
    input  wire logic [31:0] i_now_us,
    input  wire logic signed [31:0] i_target_speed,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic signed [31:0] o_delta_ticks,
    output logic signed [31:0] o_measured_speed,
    output logic [DUTY_BITS-1:0] o_duty,
    output logic             o_drive_dir,
    output logic             o_dir_changed
);
    import ecpid_pkg::*;

    t_cfg  r_cfg;
    t_item push_item, q_item;
    logic  push, pop, q_full, q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp      <= KP_RESET;
            r_cfg.ki      <= '0;
            r_cfg.kd      <= '0;
            r_cfg.max_int <= MAX_INT_RESET;
            r_cfg.scale   <= SCALE_RESET;
            r_cfg.window  <= WINDOW_RESET;
            r_cfg.reverse <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_KP:      r_cfg.kp      <= $signed(i_cfg_data[31:0]);
                CFG_KI:      r_cfg.ki      <= $signed(i_cfg_data[31:0]);
                CFG_KD:      r_cfg.kd      <= $signed(i_cfg_data[31:0]);
                CFG_MAX_INT: r_cfg.max_int <= i_cfg_data;
                CFG_SCALE:   r_cfg.scale   <= i_cfg_data[31:0];
                CFG_WINDOW:  r_cfg.window  <= i_cfg_data[19:0];
                CFG_REVERSE: r_cfg.reverse <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    ecpid_front #(.TICK_BITS(TICK_BITS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_stall        (o_in_stall),
        .i_cmd          (i_cmd),
        .i_pin_a        (i_pin_a),
        .i_pin_b        (i_pin_b),
        .i_now_us       (i_now_us),
        .i_target_speed (i_target_speed),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_item         (push_item)
    );

    ecpid_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    ecpid_back #(.DUTY_BITS(DUTY_BITS), .TICK_BITS(TICK_BITS)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_q_empty        (q_empty),
        .i_q_item         (q_item),
        .o_q_pop          (pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_delta_ticks    (o_delta_ticks),
        .o_measured_speed (o_measured_speed),
        .o_duty           (o_duty),
        .o_drive_dir      (o_drive_dir),
        .o_dir_changed    (o_dir_changed)
    );
endmodule
`default_nettype wire

@@ rtl/core/ecpid_div.sv @@
// ----------------------------------------------------------------------------
// ecpid_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ecpid_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [63:0]      o_quot
);
    logic [63:0] r_q;
    logic [31:0] r_rem;
    logic [31:0] r_dvs;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [32:0] rem_sh;
    logic        ge;

    assign rem_sh = {r_rem, r_q[63]};
    assign ge     = rem_sh >= {1'b0, r_dvs};
    assign o_done = r_busy && (r_cnt == 7'd0);
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 7'd64;
        end else if (r_busy) begin
            if (r_cnt == 7'd0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy && !o_done) begin
            r_rem <= ge ? 32'(rem_sh - {1'b0, r_dvs}) : rem_sh[31:0];
            r_q   <= {r_q[62:0], ge};
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/ecpid_fifo.sv @@
// ----------------------------------------------------------------------------
// ecpid_fifo
// Two-entry queue of control updates between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module ecpid_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ecpid_pkg::t_item i_item,
    input  wire logic          i_pop,
    output ecpid_pkg::t_item   o_item,
    output logic               o_full,
    output logic               o_empty
);
    import ecpid_pkg::*;

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_item  = r_mem[r_rp];
    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/ecpid_front.sv @@
// ----------------------------------------------------------------------------
// ecpid_front
// Accept transactions, count encoder ticks, queue control updates.
// ----------------------------------------------------------------------------
`default_nettype none
module ecpid_front #(
    parameter int TICK_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_cmd,
    input  wire logic        i_pin_a,
    input  wire logic        i_pin_b,
    input  wire logic [31:0] i_now_us,
    input  wire logic signed [31:0] i_target_speed,
    input  wire logic        i_q_full,
    output logic             o_push,
    output ecpid_pkg::t_item o_item
);
    import ecpid_pkg::*;

    logic [1:0]           r_last_pins;
    logic [TICK_BITS-1:0] r_tick;
    logic                 acc;
    logic signed [1:0]    stp;

    assign o_stall = i_q_full;
    assign acc     = i_valid && !o_stall;
    assign o_push  = acc && i_cmd;
    assign stp     = quad_step({r_last_pins, i_pin_a, i_pin_b});

    always_comb begin
        o_item.now    = i_now_us;
        o_item.target = i_target_speed;
        o_item.ticks  = 32'(r_tick);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pins <= '0;
            r_tick      <= '0;
        end else if (acc && !i_cmd) begin
            r_last_pins <= {i_pin_a, i_pin_b};
            r_tick      <= r_tick + TICK_BITS'(stp);
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/ecpid_back.sv @@
// ----------------------------------------------------------------------------
// ecpid_back
// Sequence speed estimate, PID and duty over a shared multiplier and divider.
// ----------------------------------------------------------------------------
`default_nettype none
module ecpid_back #(
    parameter int DUTY_BITS = 12,
    parameter int TICK_BITS = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ecpid_pkg::t_cfg i_cfg,
    input  wire logic           i_q_empty,
    input  wire ecpid_pkg::t_item i_q_item,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output logic signed [31:0]  o_delta_ticks,
    output logic signed [31:0]  o_measured_speed,
    output logic [DUTY_BITS-1:0] o_duty,
    output logic                o_drive_dir,
    output logic                o_dir_changed
);
    import ecpid_pkg::*;

    localparam logic [DUTY_BITS-1:0] FULL = '1;

    t_state r_state, n_state;

    logic [31:0]          r_now, r_dt, r_since, r_td_mag;
    logic [TICK_BITS-1:0] r_cur;
    logic signed [31:0]   r_tgt, r_delta;
    logic                 r_tz, r_upd, r_td_neg;
    logic [TICK_BITS-1:0] r_tiu, r_tls_k;
    logic [31:0]          r_tlu, r_tls_t;
    logic signed [31:0]   r_speed, r_lerr, r_err;
    logic signed [47:0]   r_integ;
    logic                 r_ldir;
    logic signed [32:0]   r_diff;
    logic signed [48:0]   r_p, r_d;
    logic signed [41:0]   r_i;
    logic [47:0]          r_ilo;
    logic signed [51:0]   r_power;
    logic [DUTY_BITS-1:0] r_duty;
    logic [63:0]          r_prod;

    logic [31:0]          mul_a, mul_b;
    logic                 div_start, div_done;
    logic [63:0]          div_dvd, div_q;
    logic [31:0]          div_dvs;
    logic                 out_free;

    logic [TICK_BITS-1:0] cur_w;
    logic signed [TICK_BITS-1:0] dlt_w, tdf_w;
    logic signed [31:0]   td32, tin, tgt_w;
    logic [31:0]          dt_w, since_w;
    logic                 upd_w;
    logic signed [32:0]   e33;
    logic [49:0]          mp_w;
    logic signed [50:0]   smp, pm, maxi;
    logic [47:0]          imag;
    logic [32:0]          dmag;
    logic [31:0]          kdmag;
    logic [63:0]          xd, rr;
    logic [40:0]          rc;
    logic [51:0]          pmag;
    logic [16+DUTY_BITS-1:0] dprod;

    ecpid_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    assign out_free = !o_out_valid || !i_out_stall;

    always_comb begin
        cur_w   = i_q_item.ticks[TICK_BITS-1:0];
        dlt_w   = $signed(cur_w - r_tiu);
        tdf_w   = $signed(cur_w - r_tls_k);
        td32    = 32'(tdf_w);
        dt_w    = i_q_item.now - r_tlu;
        since_w = i_q_item.now - r_tls_t;
        upd_w   = (since_w >= 32'(i_cfg.window)) && (since_w != 32'd0);
        tin     = i_q_item.target;
        if (i_cfg.reverse) begin
            tgt_w = (tin == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -tin;
        end else begin
            tgt_w = tin;
        end
        e33   = 33'(r_speed) - 33'(r_tgt);
        mp_w  = (r_prod > PROD_CAP) ? PROD_CAP[49:0] : r_prod[49:0];
        smp   = r_err[31] ? -$signed({1'b0, mp_w}) : $signed({1'b0, mp_w});
        pm    = 51'(r_integ) + smp;
        maxi  = $signed({4'b0, i_cfg.max_int});
        imag  = r_integ[47] ? 48'(-r_integ) : 48'(r_integ);
        dmag  = r_diff[32] ? 33'(-r_diff) : 33'(r_diff);
        kdmag = mag32(i_cfg.kd);
        xd    = r_prod + (dmag[32] ? {kdmag, 32'b0} : 64'b0);
        rr    = {r_prod[47:0], 16'b0} + 64'(r_ilo);
        rc    = (rr > INT_CAP) ? INT_CAP[40:0] : rr[40:0];
        pmag  = r_power[51] ? 52'(-r_power) : 52'(r_power);
        dprod = pmag[15:0] * FULL;
    end

    always_comb begin
        unique case (r_state)
            S_SPDM:  begin mul_a = r_td_mag;        mul_b = i_cfg.scale;          end
            S_INTM:  begin mul_a = mag32(r_err);    mul_b = r_dt;                 end
            S_INTA:  begin mul_a = mag32(i_cfg.kp); mul_b = mag32(r_err);         end
            S_PA:    begin mul_a = imag[31:0];      mul_b = mag32(i_cfg.ki);      end
            S_IA1:   begin mul_a = 32'(imag[47:32]); mul_b = mag32(i_cfg.ki);     end
            S_IA2:   begin mul_a = kdmag;           mul_b = dmag[31:0];           end
            default: begin mul_a = '0;              mul_b = '0;                   end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_q_pop   = 1'b0;
        div_start = 1'b0;
        div_dvd   = r_prod;
        div_dvs   = r_since;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = upd_w ? S_SPDM : S_ERR;
                end
            end
            S_SPDM: n_state = S_SPDD;
            S_SPDD: begin
                div_start = 1'b1;
                n_state   = S_SPDW;
            end
            S_SPDW: if (div_done) n_state = S_ERR;
            S_ERR:  n_state = S_INTM;
            S_INTM: n_state = S_INTA;
            S_INTA: n_state = S_PA;
            S_PA:   n_state = S_IA1;
            S_IA1:  n_state = S_IA2;
            S_IA2:  n_state = S_DA;
            S_DA: begin
                div_dvd = {16'b0, xd[63:16]};
                div_dvs = r_dt;
                if (r_dt != 32'd0) begin
                    div_start = 1'b1;
                    n_state   = S_DW;
                end else begin
                    n_state = S_PWR;
                end
            end
            S_DW:   if (div_done) n_state = S_PWR;
            S_PWR:  n_state = S_DUTY;
            S_DUTY: n_state = S_FIN;
            S_FIN:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tiu       <= '0;
            r_tls_k     <= '0;
            r_tlu       <= '0;
            r_tls_t     <= '0;
            r_speed     <= '0;
            r_integ     <= '0;
            r_lerr      <= '0;
            r_ldir      <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall && (r_state != S_FIN)) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_SPDW: begin
                    if (div_done) begin
                        if (r_td_neg) begin
                            r_speed <= (|div_q[63:31]) ? 32'sh8000_0000
                                                       : -$signed(div_q[31:0]);
                        end else begin
                            r_speed <= (|div_q[63:31]) ? 32'sh7FFF_FFFF
                                                       : $signed(div_q[31:0]);
                        end
                    end
                end
                S_INTA: begin
                    if (pm > maxi) begin
                        r_integ <= maxi[47:0];
                    end else if (pm < -maxi) begin
                        r_integ <= 48'(-maxi);
                    end else begin
                        r_integ <= pm[47:0];
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        o_out_valid      <= 1'b1;
                        o_delta_ticks    <= r_delta;
                        o_measured_speed <= r_speed;
                        o_duty           <= r_duty;
                        o_drive_dir      <= !r_power[51];
                        o_dir_changed    <= (!r_power[51]) != r_ldir;
                        r_ldir           <= !r_power[51];
                        r_lerr           <= r_err;
                        r_tlu            <= r_now;
                        r_tiu            <= r_cur;
                        if (r_upd) begin
                            r_tls_t <= r_now;
                            r_tls_k <= r_cur;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_now    <= i_q_item.now;
                r_cur    <= cur_w;
                r_dt     <= dt_w;
                r_since  <= since_w;
                r_upd    <= upd_w;
                r_delta  <= 32'(dlt_w);
                r_td_neg <= td32[31];
                r_td_mag <= mag32(td32);
                r_tgt    <= tgt_w;
                r_tz     <= tgt_w == 32'sd0;
            end
            S_ERR: begin
                if (e33[32] != e33[31]) begin
                    r_err <= e33[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end else begin
                    r_err <= e33[31:0];
                end
            end
            S_INTM: r_diff <= 33'(r_err) - 33'(r_lerr);
            S_PA: begin
                r_p <= (i_cfg.kp[31] ^ r_err[31]) ? -$signed({1'b0, r_prod[63:16]})
                                                  : $signed({1'b0, r_prod[63:16]});
            end
            S_IA1: r_ilo <= r_prod[63:16];
            S_IA2: begin
                r_i <= (r_integ[47] ^ i_cfg.ki[31]) ? -$signed({1'b0, rc})
                                                    : $signed({1'b0, rc});
            end
            S_DA: r_d <= '0;
            S_DW: begin
                if (div_done) begin
                    r_d <= (i_cfg.kd[31] ^ r_diff[32]) ? -$signed({1'b0, div_q[47:0]})
                                                       : $signed({1'b0, div_q[47:0]});
                end
            end
            S_PWR: begin
                r_power <= r_tz ? 52'(r_p) : 52'(r_p) + 52'(r_i) + 52'(r_d);
            end
            S_DUTY: begin
                r_duty <= (|pmag[51:16]) ? FULL : dprod[16+DUTY_BITS-1:16];
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire
